@@ hdl/three_digit_value_and_time_formatter_core_macros.svh @@
// Assertion macros shared by the formatter RTL.
// No dependencies; included by modules that carry concurrent checks.
// Clock and active-low reset are passed in so each check names them.
`ifndef THREE_DIGIT_VALUE_AND_TIME_FORMATTER_CORE_MACROS_SVH
`define THREE_DIGIT_VALUE_AND_TIME_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication.
`define TDVTF_CHECK(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdvtf check failed");

// Next-cycle implication.
`define TDVTF_CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdvtf next-cycle check failed");

`endif

@@ hdl/tdvtf_pkg.sv @@
// Shared types and constants of the three-digit value/time formatter.
// No dependencies; imported by every formatter module.
`timescale 1ns / 1ps

package tdvtf_pkg;

    localparam int VALUE_W  = 32;
    localparam int PT_W     = 2;
    localparam int UNITS_W  = 3;
    localparam int SYM_W    = 4;
    localparam int MAG_W    = 26;          // clamped magnitude, holds 36000000
    localparam int PROD_W   = 2 * MAG_W;   // reciprocal product
    localparam int T_W      = 10;          // scaled value, at most 1000
    localparam int Q_W      = 5;           // t / 60
    localparam int Q_PROD_W = 21;
    localparam int H_PROD_W = 16;
    localparam int REM_W    = 7;
    localparam int R_PROD_W = 15;

    // unit mask bits
    localparam int UNIT_MS  = 0;
    localparam int UNIT_SEC = 1;
    localparam int UNIT_MIN = 2;

    // symbol codes
    localparam logic [SYM_W-1:0] SYM_MINUS     = 4'd10;
    localparam logic [SYM_W-1:0] SYM_MINUS_ONE = 4'd11;
    localparam logic [SYM_W-1:0] SYM_LOW       = 4'd12;
    localparam logic [SYM_W-1:0] SYM_HIGH      = 4'd13;
    localparam logic [SYM_W-1:0] SYM_DIGIT_MAX = 4'd9;

    // point choice
    localparam logic [PT_W-1:0] PT_NONE   = 2'd0;
    localparam logic [PT_W-1:0] PT_SECOND = 2'd1;
    localparam logic [PT_W-1:0] PT_FIRST  = 2'd2;

    // unit fit limits (signed ms)
    localparam logic signed [VALUE_W-1:0] MS_LIMIT  = 32'sd1000;
    localparam logic signed [VALUE_W-1:0] SEC_LIMIT = 32'sd10000;
    localparam logic signed [VALUE_W-1:0] MIN_LIMIT = 32'sd600000;

    // magnitude saturation per mode; beyond these the display is L or H anyway
    localparam logic [MAG_W-1:0] MAX_DIRECT = 26'd1000;
    localparam logic [MAG_W-1:0] MAX_SEC    = 26'd9999;
    localparam logic [MAG_W-1:0] MAX_MIN    = 26'd599999;
    localparam logic [MAG_W-1:0] MAX_HR     = 26'd36000000;

    // exact reciprocals over the saturated ranges: q = (m * R) >> S
    localparam logic [MAG_W-1:0] RECIP_1     = 26'd1;
    localparam logic [MAG_W-1:0] RECIP_10    = 26'd52429;
    localparam int               SH_10       = 19;
    localparam logic [MAG_W-1:0] RECIP_1000  = 26'd1073742;
    localparam int               SH_1000     = 30;
    localparam logic [MAG_W-1:0] RECIP_60000 = 26'd36650388;
    localparam int               SH_60000    = 41;
    localparam logic [10:0]      RECIP_60    = 11'd1093;
    localparam int               SH_60       = 16;
    localparam logic [5:0]       RECIP_100   = 6'd41;
    localparam int               SH_100      = 12;
    localparam logic [7:0]       RECIP_10D   = 8'd205;
    localparam int               SH_10D      = 11;

    localparam logic [T_W-1:0]   D_MAX      = 10'd1000;
    localparam logic [T_W-1:0]   D_NEG_MAX  = 10'd199;
    localparam logic [T_W-1:0]   D_POS_MAX  = 10'd999;

    typedef enum logic [1:0] {
        MODE_DIRECT,   // integer or milliseconds, no scaling
        MODE_SEC,      // s.cc, hundredths of a second from ms / 10
        MODE_MIN,      // min:sec from ms / 1000
        MODE_HR        // hr:min from ms / 60000
    } t_mode;

    typedef struct packed {
        logic        neg;
        logic [1:0]  pt;
        t_mode       mode;
    } t_side;

endpackage

@@ hdl/tdvtf_front.sv @@
// Front end: unit selection, absolute value, per-mode saturation (2 stages).
// Depends on tdvtf_pkg.
`timescale 1ns / 1ps

module tdvtf_front import tdvtf_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_func,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [PT_W-1:0]           i_point_position,
    input  logic [UNITS_W-1:0]        i_time_units,
    input  logic                      i_blink_point,
    input  logic                      i_blink_phase,
    output logic                      o_valid,
    output t_side                     o_side,
    output logic [MAG_W-1:0]          o_mag
);

    logic               r_s1_vld;
    t_side              r_s1_side;
    logic [VALUE_W-1:0] r_s1_mag;
    t_side              n_s1_side;
    logic [VALUE_W-1:0] n_s1_mag;
    logic [VALUE_W-1:0] w_raw;
    logic [PT_W-1:0]    w_sep;

    logic               r_s2_vld;
    t_side              r_s2_side;
    logic [MAG_W-1:0]   r_s2_mag;
    logic [MAG_W-1:0]   n_s2_mag;
    logic [MAG_W-1:0]   w_limit;

    // stage 1
    assign w_raw = i_value;
    assign w_sep = (i_blink_phase || !i_blink_point) ? PT_FIRST : PT_NONE;

    always_comb begin
        n_s1_side.neg = w_raw[VALUE_W-1];
        n_s1_mag      = w_raw[VALUE_W-1] ? (~w_raw + 32'd1) : w_raw;
        if (!i_func) begin
            n_s1_side.mode = MODE_DIRECT;
            n_s1_side.pt   = i_point_position;
        end else if (i_time_units[UNIT_MS] && (i_value < MS_LIMIT)) begin
            n_s1_side.mode = MODE_DIRECT;
            n_s1_side.pt   = PT_NONE;
        end else if (i_time_units[UNIT_SEC] && (i_value < SEC_LIMIT)) begin
            n_s1_side.mode = MODE_SEC;
            n_s1_side.pt   = PT_FIRST;
        end else if (i_time_units[UNIT_MIN] && (i_value < MIN_LIMIT)) begin
            n_s1_side.mode = MODE_MIN;
            n_s1_side.pt   = w_sep;
        end else begin
            n_s1_side.mode = MODE_HR;
            n_s1_side.pt   = w_sep;
        end
    end

    // stage 2
    always_comb begin
        case (r_s1_side.mode)
            MODE_DIRECT: w_limit = MAX_DIRECT;
            MODE_SEC:    w_limit = MAX_SEC;
            MODE_MIN:    w_limit = MAX_MIN;
            MODE_HR:     w_limit = MAX_HR;
            default:     w_limit = MAX_DIRECT;
        endcase
        n_s2_mag = (r_s1_mag > VALUE_W'(w_limit)) ? w_limit : r_s1_mag[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_side <= n_s1_side;
        r_s1_mag  <= n_s1_mag;
        r_s2_side <= r_s1_side;
        r_s2_mag  <= n_s2_mag;
    end

    assign o_valid = r_s2_vld;
    assign o_side  = r_s2_side;
    assign o_mag   = r_s2_mag;

endmodule

@@ hdl/tdvtf_scale.sv @@
// Scaling: reciprocal multiply by the unit divisor, then the x:yy fold (3 stages).
// Depends on tdvtf_pkg.
`timescale 1ns / 1ps

module tdvtf_scale import tdvtf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_side            i_side,
    input  logic [MAG_W-1:0] i_mag,
    output logic             o_valid,
    output t_side            o_side,
    output logic [T_W-1:0]   o_d
);

    logic [MAG_W-1:0]    w_recip;
    logic [PROD_W-1:0]   n_s3_prod;
    logic                r_s3_vld;
    t_side               r_s3_side;
    logic [PROD_W-1:0]   r_s3_prod;

    logic [T_W-1:0]      w_t;
    logic [Q_PROD_W-1:0] w_q_prod;
    logic                r_s4_vld;
    t_side               r_s4_side;
    logic [T_W-1:0]      r_s4_t;
    logic [Q_W-1:0]      r_s4_q;

    logic [T_W-1:0]      n_s5_d;
    logic                r_s5_vld;
    t_side               r_s5_side;
    logic [T_W-1:0]      r_s5_d;

    // stage 3: one 26x26 multiply
    always_comb begin
        case (i_side.mode)
            MODE_DIRECT: w_recip = RECIP_1;
            MODE_SEC:    w_recip = RECIP_10;
            MODE_MIN:    w_recip = RECIP_1000;
            MODE_HR:     w_recip = RECIP_60000;
            default:     w_recip = RECIP_1;
        endcase
        n_s3_prod = PROD_W'(i_mag) * PROD_W'(w_recip);
    end

    // stage 4: pick the quotient bits, then t / 60
    always_comb begin
        case (r_s3_side.mode)
            MODE_DIRECT: w_t = r_s3_prod[T_W-1:0];
            MODE_SEC:    w_t = r_s3_prod[SH_10 +: T_W];
            MODE_MIN:    w_t = r_s3_prod[SH_1000 +: T_W];
            MODE_HR:     w_t = r_s3_prod[SH_60000 +: T_W];
            default:     w_t = r_s3_prod[T_W-1:0];
        endcase
        w_q_prod = Q_PROD_W'(w_t) * Q_PROD_W'(RECIP_60);
    end

    // stage 5: q*100 + (t - q*60) == t + 40*q
    always_comb begin
        if (r_s4_side.mode == MODE_MIN || r_s4_side.mode == MODE_HR) begin
            n_s5_d = T_W'(r_s4_t + T_W'(r_s4_q) * 10'd40);
        end else begin
            n_s5_d = r_s4_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else begin
            r_s3_vld <= i_valid;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_side <= i_side;
        r_s3_prod <= n_s3_prod;
        r_s4_side <= r_s3_side;
        r_s4_t    <= w_t;
        r_s4_q    <= w_q_prod[SH_60 +: Q_W];
        r_s5_side <= r_s4_side;
        r_s5_d    <= n_s5_d;
    end

    assign o_valid = r_s5_vld;
    assign o_side  = r_s5_side;
    assign o_d     = r_s5_d;

endmodule

@@ hdl/tdvtf_digits.sv @@
// Digit split, L/H range flags and symbol/point formatting (3 stages).
// Depends on tdvtf_pkg and the formatter assertion macros header.
`timescale 1ns / 1ps
`include "three_digit_value_and_time_formatter_core_macros.svh"

module tdvtf_digits import tdvtf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_side            i_side,
    input  logic [T_W-1:0]   i_d,
    output logic             o_valid,
    output logic [SYM_W-1:0] o_first_symbol,
    output logic [SYM_W-1:0] o_second_symbol,
    output logic [SYM_W-1:0] o_third_symbol,
    output logic             o_first_point,
    output logic             o_second_point
);

    logic [H_PROD_W-1:0] w_h_prod;
    logic                w_neg;
    logic                r_s6_vld;
    logic [PT_W-1:0]     r_s6_pt;
    logic [T_W-1:0]      r_s6_d;
    logic [SYM_W-1:0]    r_s6_h;
    logic                r_s6_neg;
    logic                r_s6_low;
    logic                r_s6_high;

    logic [REM_W-1:0]    w_rem;
    logic [R_PROD_W-1:0] w_r_prod;
    logic                r_s7_vld;
    logic [PT_W-1:0]     r_s7_pt;
    logic [SYM_W-1:0]    r_s7_h;
    logic [REM_W-1:0]    r_s7_rem;
    logic [SYM_W-1:0]    r_s7_tens;
    logic                r_s7_neg;
    logic                r_s7_low;
    logic                r_s7_high;

    logic [SYM_W-1:0]    w_ones;
    logic [SYM_W-1:0]    n_first;
    logic [SYM_W-1:0]    n_second;
    logic [SYM_W-1:0]    n_third;
    logic                n_fp;
    logic                n_sp;
    logic                r_out_vld;
    logic [SYM_W-1:0]    r_first;
    logic [SYM_W-1:0]    r_second;
    logic [SYM_W-1:0]    r_third;
    logic                r_fp;
    logic                r_sp;

    // stage 6: hundreds and range flags; a zero magnitude is never negative
    assign w_h_prod = H_PROD_W'(i_d) * H_PROD_W'(RECIP_100);
    assign w_neg    = i_side.neg && (i_d != '0);

    // stage 7: remainder below 100 and tens
    assign w_rem    = REM_W'(r_s6_d - T_W'(r_s6_h) * 10'd100);
    assign w_r_prod = R_PROD_W'(w_rem) * R_PROD_W'(RECIP_10D);

    // stage 8: ones and symbol selection
    assign w_ones = SYM_W'(r_s7_rem - REM_W'(r_s7_tens) * 7'd10);

    always_comb begin
        if (r_s7_low) begin
            n_first  = SYM_LOW;
            n_second = SYM_LOW;
            n_third  = SYM_LOW;
            n_fp     = 1'b0;
            n_sp     = 1'b0;
        end else if (r_s7_high) begin
            n_first  = SYM_HIGH;
            n_second = SYM_HIGH;
            n_third  = SYM_HIGH;
            n_fp     = 1'b0;
            n_sp     = 1'b0;
        end else if (r_s7_neg) begin
            // magnitude here is at most 199, so hundreds is 0 or 1
            n_first  = (r_s7_h != '0) ? SYM_MINUS_ONE : SYM_MINUS;
            n_second = r_s7_tens;
            n_third  = w_ones;
            n_fp     = 1'b0;
            n_sp     = (r_s7_pt == PT_SECOND);
        end else begin
            n_first  = r_s7_h;
            n_second = r_s7_tens;
            n_third  = w_ones;
            n_fp     = (r_s7_pt == PT_FIRST);
            n_sp     = (r_s7_pt == PT_SECOND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s6_vld  <= i_valid;
            r_s7_vld  <= r_s6_vld;
            r_out_vld <= r_s7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_pt   <= i_side.pt;
        r_s6_d    <= i_d;
        r_s6_h    <= w_h_prod[SH_100 +: SYM_W];
        r_s6_neg  <= w_neg;
        r_s6_low  <= w_neg && (i_d > D_NEG_MAX);
        r_s6_high <= !w_neg && (i_d > D_POS_MAX);
        r_s7_pt   <= r_s6_pt;
        r_s7_h    <= r_s6_h;
        r_s7_rem  <= w_rem;
        r_s7_tens <= w_r_prod[SH_10D +: SYM_W];
        r_s7_neg  <= r_s6_neg;
        r_s7_low  <= r_s6_low;
        r_s7_high <= r_s6_high;
        r_first   <= n_first;
        r_second  <= n_second;
        r_third   <= n_third;
        r_fp      <= n_fp;
        r_sp      <= n_sp;
    end

    assign o_valid         = r_out_vld;
    assign o_first_symbol  = r_first;
    assign o_second_symbol = r_second;
    assign o_third_symbol  = r_third;
    assign o_first_point   = r_fp;
    assign o_second_point  = r_sp;

    // scaled magnitude never exceeds the saturation point
    `TDVTF_CHECK(a_d_range, i_clk, i_rst_n, r_s6_vld, r_s6_d <= D_MAX)
    // digit stage keeps pace with the hundreds stage
    `TDVTF_CHECK_NEXT(a_pipe_step, i_clk, i_rst_n, r_s6_vld, r_s7_vld)
    // L and H fill all three places and never light a point
    `TDVTF_CHECK(a_range_fill, i_clk, i_rst_n, r_out_vld && (r_first == SYM_LOW || r_first == SYM_HIGH), r_second == r_first && r_third == r_first && !r_fp && !r_sp)
    // a minus sign is followed by two plain digits and no first point
    `TDVTF_CHECK(a_neg_digits, i_clk, i_rst_n, r_out_vld && (r_first == SYM_MINUS || r_first == SYM_MINUS_ONE), !r_fp && r_second <= SYM_DIGIT_MAX && r_third <= SYM_DIGIT_MAX)

endmodule

@@ hdl/three_digit_value_and_time_formatter_core.sv @@
// Top level of the three-digit value/time formatter.
// Depends on tdvtf_pkg, tdvtf_front, tdvtf_scale and tdvtf_digits.
`timescale 1ns / 1ps
//
//  Channel   | Handshake          | Payload
//  ----------+--------------------+-----------------------------------------------
//  command   | start in, busy out | i_func, i_value, i_point_position,
//            |                    | i_time_units, i_blink_point, i_blink_phase
//  result    | o_valid strobe     | o_first/second/third_symbol, o_first/second_point
//
//  One transaction per clock: busy is held low, so a command is taken on every
//  cycle that start is high. Its result strobes after the 8 register stages:
//  decode/abs, saturate, reciprocal multiply, quotient select with /60, minute
//  fold, hundreds, tens, ones/format. Reset (synchronous, i_rst_n low) clears
//  only the stage valid bits; payload registers are not reset. The receiver
//  cannot stall, so nothing ever waits.
//
//  Integer mode: <-199 shows LLL, >999 shows HHH, -199..-100 minus-one and two
//  digits, -99..-1 minus and two digits, else three digits with leading zeros.
//  Time mode picks the first allowed unit that fits (ms, s.cc, min:sec) and
//  falls back to hr:min. The value is handled as sign plus magnitude; the
//  magnitude is saturated per unit to a point where the display is already
//  L or H, which keeps every divisor a short reciprocal multiply.

module three_digit_value_and_time_formatter_core import tdvtf_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_func,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [PT_W-1:0]           i_point_position,
    input  logic [UNITS_W-1:0]        i_time_units,
    input  logic                      i_blink_point,
    input  logic                      i_blink_phase,
    output logic                      o_valid,
    output logic [SYM_W-1:0]          o_first_symbol,
    output logic [SYM_W-1:0]          o_second_symbol,
    output logic [SYM_W-1:0]          o_third_symbol,
    output logic                      o_first_point,
    output logic                      o_second_point
);

    logic             w_accept;

    // front -> scale
    logic             w_fr_vld;
    t_side            w_fr_side;
    logic [MAG_W-1:0] w_fr_mag;

    // scale -> digits
    logic             w_sc_vld;
    t_side            w_sc_side;
    logic [T_W-1:0]   w_sc_d;

    // fully pipelined, never back-pressured
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // stages 1-2: unit choice, sign/magnitude, saturation
    tdvtf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_accept),
        .i_func           (i_func),
        .i_value          (i_value),
        .i_point_position (i_point_position),
        .i_time_units     (i_time_units),
        .i_blink_point    (i_blink_point),
        .i_blink_phase    (i_blink_phase),
        .o_valid          (w_fr_vld),
        .o_side           (w_fr_side),
        .o_mag            (w_fr_mag)
    );

    // stages 3-5: divide by unit, fold into hundreds:units form
    tdvtf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_vld),
        .i_side  (w_fr_side),
        .i_mag   (w_fr_mag),
        .o_valid (w_sc_vld),
        .o_side  (w_sc_side),
        .o_d     (w_sc_d)
    );

    // stages 6-8: digits, L/H, symbol and point registers
    tdvtf_digits u_digits (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_sc_vld),
        .i_side          (w_sc_side),
        .i_d             (w_sc_d),
        .o_valid         (o_valid),
        .o_first_symbol  (o_first_symbol),
        .o_second_symbol (o_second_symbol),
        .o_third_symbol  (o_third_symbol),
        .o_first_point   (o_first_point),
        .o_second_point  (o_second_point)
    );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for three_digit_value_and_time_formatter_core.
// Depends on tdvtf_pkg and the core RTL; predicts each display from the command
// fields and compares every strobed result against the oldest prediction.
`timescale 1ns / 1ps

module tb;
    import tdvtf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 24;      // pipeline is 8 deep; margin on top
    localparam int RANDOM_CMDS  = 1400;

    // One command as it sits on the input ports.
    typedef struct {
        logic                      func;
        logic signed [VALUE_W-1:0] value;
        logic [PT_W-1:0]           pt;
        logic [UNITS_W-1:0]        units;
        logic                      blink;
        logic                      phase;
    } t_cmd;

    // One result: three symbols and two point flags.
    typedef struct packed {
        logic [SYM_W-1:0] sym0;
        logic [SYM_W-1:0] sym1;
        logic [SYM_W-1:0] sym2;
        logic             pt0;
        logic             pt1;
    } t_display;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_func = 1'b0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic [PT_W-1:0]           i_point_position = '0;
    logic [UNITS_W-1:0]        i_time_units = '0;
    logic                      i_blink_point = 1'b0;
    logic                      i_blink_phase = 1'b0;
    logic                      o_valid;
    logic [SYM_W-1:0]          o_first_symbol;
    logic [SYM_W-1:0]          o_second_symbol;
    logic [SYM_W-1:0]          o_third_symbol;
    logic                      o_first_point;
    logic                      o_second_point;

    t_cmd     pending_cmds[$];       // commands not yet on the bus
    t_display expected_displays[$];  // predictions waiting for their strobe
    t_cmd     on_bus;                // command currently presented
    int       n_sent      = 0;
    int       n_checked   = 0;
    int       n_int_mode  = 0;
    int       n_time_mode = 0;
    int       n_errors    = 0;
    int       n_cycles    = 0;
    int       total_cmds  = 0;
    int       burst_left  = 1;
    int       gap_left    = 0;

    three_digit_value_and_time_formatter_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_value          (i_value),
        .i_point_position (i_point_position),
        .i_time_units     (i_time_units),
        .i_blink_point    (i_blink_point),
        .i_blink_phase    (i_blink_phase),
        .o_valid          (o_valid),
        .o_first_symbol   (o_first_symbol),
        .o_second_symbol  (o_second_symbol),
        .o_third_symbol   (o_third_symbol),
        .o_first_point    (o_first_point),
        .o_second_point   (o_second_point)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Integer display rules: LLL / HHH saturation, minus-one for -199..-100,
    // minus for -99..-1, three zero-padded digits otherwise.
    function automatic t_display show_number(longint v, logic [PT_W-1:0] pt);
        t_display d;
        longint   m;
        d = '0;
        if (v < -199) begin
            d.sym0 = SYM_LOW;
            d.sym1 = SYM_LOW;
            d.sym2 = SYM_LOW;
        end else if (v > 999) begin
            d.sym0 = SYM_HIGH;
            d.sym1 = SYM_HIGH;
            d.sym2 = SYM_HIGH;
        end else if (v <= -100) begin
            m = -(v % 100);  // remainder is negative here, so flip it
            d.sym0 = SYM_MINUS_ONE;
            d.sym1 = SYM_W'(m / 10);
            d.sym2 = SYM_W'(m % 10);
            d.pt1  = (pt == PT_SECOND);
        end else if (v < 0) begin
            m = -v;
            d.sym0 = SYM_MINUS;
            d.sym1 = SYM_W'(m / 10);
            d.sym2 = SYM_W'(m % 10);
            d.pt1  = (pt == PT_SECOND);
        end else begin
            d.sym0 = SYM_W'(v / 100);
            d.sym1 = SYM_W'((v % 100) / 10);
            d.sym2 = SYM_W'(v % 10);
            d.pt0  = (pt == PT_FIRST);
            d.pt1  = (pt == PT_SECOND);
        end
        return d;
    endfunction

    // Full command -> display. Time mode takes the first enabled unit that
    // fits and falls back to hr:min. SV division truncates toward zero and
    // the remainder follows the dividend, which is what negative durations need.
    function automatic t_display format_display(t_cmd c);
        longint          v;
        longint          t;
        logic [PT_W-1:0] sep;
        v   = longint'(c.value);
        sep = (c.phase || !c.blink) ? PT_FIRST : PT_NONE;
        if (!c.func)
            return show_number(v, c.pt);
        if (c.units[UNIT_MS] && v < 1000)
            return show_number(v, PT_NONE);
        if (c.units[UNIT_SEC] && v < 10000)
            return show_number(v / 10, PT_FIRST);
        if (c.units[UNIT_MIN] && v < 600000) begin
            t = v / 1000;
            return show_number((t / 60) * 100 + (t % 60), sep);
        end
        t = v / 60000;
        return show_number((t / 60) * 100 + (t % 60), sep);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_cmd(logic f, logic signed [VALUE_W-1:0] v, logic [PT_W-1:0] p,
                           logic [UNITS_W-1:0] u, logic b, logic ph);
        t_cmd c;
        c.func  = f;
        c.value = v;
        c.pt    = p;
        c.units = u;
        c.blink = b;
        c.phase = ph;
        pending_cmds.push_back(c);
    endtask

    // Values spread over the regions where the display changes form, plus
    // fully random words so every value bit toggles.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int edges[9] = '{999, 1000, 9999, 10000, 599999, 600000, -100, -199, -200};
        case ($urandom_range(6, 0))
            0:       return $signed($urandom_range(1350, 0)) - 250;
            1:       return $signed($urandom_range(12000, 0));
            2:       return $signed($urandom_range(700000, 0));
            3:       return $signed($urandom_range(40700000, 0)) - 700000;
            4:       return $signed($urandom_range(60000, 0)) - 30000;
            5:       return edges[$urandom_range(8, 0)] + $signed($urandom_range(4, 0)) - 2;
            default: return $signed($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Reset: held low from the start, then released once.
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: a transaction completes at an edge with start high and busy
    // low. Commands go out in bursts of random length; often a burst follows
    // the last with no gap, so long back-to-back stretches occur too.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_displays.push_back(format_display(on_bus));
                n_sent++;
                if (on_bus.func)
                    n_time_mode++;
                else
                    n_int_mode++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    on_bus = pending_cmds.pop_front();
                    i_func           <= on_bus.func;
                    i_value          <= on_bus.value;
                    i_point_position <= on_bus.pt;
                    i_time_units     <= on_bus.units;
                    i_blink_point    <= on_bus.blink;
                    i_blink_phase    <= on_bus.phase;
                    start            <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // occasional long burst; otherwise short ones
                        burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(120, 40)
                                                                : $urandom_range(12, 1);
                        gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(7, 1);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every o_valid cycle is a result that must match the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_display want;
        if (i_rst_n && o_valid) begin
            if (expected_displays.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %0d %0d %0d pts %0b%0b",
                         $time, o_first_symbol, o_second_symbol, o_third_symbol,
                         o_first_point, o_second_point);
                n_errors++;
            end else begin
                want = expected_displays.pop_front();
                check_field("first_symbol",  want.sym0, o_first_symbol);
                check_field("second_symbol", want.sym1, o_second_symbol);
                check_field("third_symbol",  want.sym2, o_third_symbol);
                check_field("first_point",   want.pt0,  o_first_point);
                check_field("second_point",  want.pt1,  o_second_point);
                n_checked++;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     n_cycles, expected_displays.size());
            $display("[three_digit_value_and_time_formatter_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Command list and end of test.
    // ------------------------------------------------------------------
    initial begin
        // integer mode: saturation ends, the minus-one band, the minus band,
        // digit range ends, and the unused point choice
        add_cmd(1'b0, 32'sh8000_0000, PT_NONE,   3'd0, 1'b0, 1'b0);
        add_cmd(1'b0, 32'sh7fff_ffff, PT_SECOND, 3'd7, 1'b1, 1'b1);
        add_cmd(1'b0, -200,           PT_SECOND, 3'd0, 1'b0, 1'b0);
        add_cmd(1'b0, -199,           PT_SECOND, 3'd0, 1'b0, 1'b0);
        add_cmd(1'b0, -100,           PT_SECOND, 3'd0, 1'b0, 1'b0);
        add_cmd(1'b0, -99,            PT_FIRST,  3'd0, 1'b0, 1'b0);
        add_cmd(1'b0, -1,             PT_SECOND, 3'd0, 1'b0, 1'b0);
        add_cmd(1'b0, 0,              PT_FIRST,  3'd0, 1'b0, 1'b0);
        add_cmd(1'b0, 999,            PT_FIRST,  3'd0, 1'b0, 1'b0);
        add_cmd(1'b0, 1000,           PT_SECOND, 3'd0, 1'b0, 1'b0);
        add_cmd(1'b0, 5,              2'd3,      3'd0, 1'b0, 1'b0);
        // time mode: each unit at its fit limit, fallback to hr:min,
        // blink phases, no unit enabled, negative durations
        add_cmd(1'b1, 999,            PT_SECOND, 3'd1, 1'b0, 1'b0);
        add_cmd(1'b1, 1000,           PT_NONE,   3'd1, 1'b1, 1'b0);
        add_cmd(1'b1, 0,              PT_NONE,   3'd2, 1'b0, 1'b0);
        add_cmd(1'b1, 9999,           PT_NONE,   3'd2, 1'b0, 1'b0);
        add_cmd(1'b1, 10000,          PT_NONE,   3'd2, 1'b0, 1'b0);
        add_cmd(1'b1, 599999,         PT_NONE,   3'd4, 1'b1, 1'b0);
        add_cmd(1'b1, 600000,         PT_NONE,   3'd4, 1'b1, 1'b1);
        add_cmd(1'b1, 35940000,       PT_NONE,   3'd0, 1'b1, 1'b0);
        add_cmd(1'b1, 59999999,       PT_NONE,   3'd0, 1'b0, 1'b0);
        add_cmd(1'b1, 32'sh7fff_ffff, PT_NONE,   3'd7, 1'b0, 1'b1);
        add_cmd(1'b1, -1,             PT_NONE,   3'd7, 1'b0, 1'b0);
        add_cmd(1'b1, -60000,         PT_NONE,   3'd4, 1'b0, 1'b0);
        add_cmd(1'b1, -5000,          PT_NONE,   3'd6, 1'b0, 1'b0);
        add_cmd(1'b1, 32'sh8000_0000, PT_NONE,   3'd7, 1'b1, 1'b1);

        for (int k = 0; k < RANDOM_CMDS; k++)
            add_cmd(1'($urandom_range(1, 0)), pick_value(),
                    PT_W'($urandom_range(3, 0)), UNITS_W'($urandom_range(7, 0)),
                    1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
        total_cmds = pending_cmds.size();

        wait (i_rst_n);
        while (n_sent < total_cmds)
            @(posedge i_clk);
        while (expected_displays.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d commands (%0d integer, %0d duration), checked %0d results",
                 n_sent, n_int_mode, n_time_mode, n_checked);
        $display("field mismatches or stray results: %0d", n_errors);
        if (n_errors == 0)
            $display("[three_digit_value_and_time_formatter_core] OK");
        else
            $display("[three_digit_value_and_time_formatter_core] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tdvtf_pkg.sv
hdl/tdvtf_front.sv
hdl/tdvtf_scale.sv
hdl/tdvtf_digits.sv
hdl/three_digit_value_and_time_formatter_core.sv
bench/tb.sv
